>>> rtl/usv_pkg.sv
// Shared widths, types and register codes of the UV sphere cell vertex generator.
`default_nettype none
package usv_pkg;
	localparam int NUM_W = 25;
	localparam int DEN_W = 9;
	localparam int QUO_W = 17;
	localparam int PHASE_W = 16;
	localparam int TRIG_W = 16;
	localparam int MAX_SEGMENTS = 256;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_SEG_AROUND = 2'd1;
	localparam logic [1:0] REG_SEG_POLE = 2'd2;

	typedef enum logic [1:0] {KIND_BAD, KIND_TOP, KIND_BOT, KIND_MID} cell_kind_t;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_word_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic bad;
	} div_tag_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic bad;
		logic [QUO_W-1:0] tu;
		logic [QUO_W-1:0] tv;
	} vtx_tag_t;
endpackage
`default_nettype wire

>>> rtl/usv_div_cell.sv
// One restoring division cell that settles a single quotient bit.
`default_nettype none
module usv_div_cell #(
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                en,
	input  usv_pkg::div_word_t  din,
	output usv_pkg::div_word_t  dout
);
	import usv_pkg::*;

	div_word_t word_q;
	div_word_t nxt;
	logic [NUM_W-1:0] trial;
	logic ge;

	always_comb begin
		trial = NUM_W'(din.den) << BIT;
		ge = din.rem >= trial;
		nxt.den = din.den;
		nxt.rem = ge ? din.rem - trial : din.rem;
		nxt.quo = din.quo | (ge ? (QUO_W'(1) << BIT) : '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign dout = word_q;
endmodule
`default_nettype wire

>>> rtl/usv_div_chain.sv
// Pipelined divider built as a row of division cells, one quotient bit per cell.
`default_nettype none
module usv_div_chain (
	input  logic                        clk,
	input  logic                        en,
	input  logic [usv_pkg::NUM_W-1:0]   num,
	input  logic [usv_pkg::DEN_W-1:0]   den,
	output logic [usv_pkg::QUO_W-1:0]   quo
);
	import usv_pkg::*;

	div_word_t words [QUO_W+1];

	assign words[0] = '{den: den, rem: num, quo: '0};

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		usv_div_cell #(.BIT(QUO_W - 1 - i)) u_cell (
			.clk  (clk),
			.en   (en),
			.din  (words[i]),
			.dout (words[i+1])
		);
	end

	assign quo = words[QUO_W].quo;
endmodule
`default_nettype wire

>>> rtl/usv_sine.sv
// Four-stage fixed-point sine of a 16-bit phase, Q1.14 result.
`default_nettype none
module usv_sine (
	input  logic                              clk,
	input  logic                              en,
	input  logic [usv_pkg::PHASE_W-1:0]       phase,
	output logic signed [usv_pkg::TRIG_W-1:0] value
);
	import usv_pkg::*;

	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [14:0] SIN_B = 15'd10512;
	localparam logic [14:0] SIN_C = 15'd1160;

	logic [14:0] x;
	logic [30:0] sq;
	logic [30:0] p2;
	logic [30:0] p3;
	logic [30:0] p4;
	logic [16:0] r4;

	logic [14:0] x_s1, x_s2, x_s3;
	logic neg_s1, neg_s2, neg_s3;
	logic [14:0] x2_s1, x2_s2;
	logic [14:0] t_s2, t_s3;

	always_comb begin
		x = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
		sq = 31'(x) * 31'(x) + 31'd8192;
		p2 = 31'(SIN_C) * 31'(x2_s1) + 31'd8192;
		p3 = 31'(t_s2) * 31'(x2_s2) + 31'd8192;
		p4 = 31'(x_s3) * 31'(t_s3) + 31'd8192;
		r4 = (p4[30:14] > 17'd16384) ? 17'd16384 : p4[30:14];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			neg_s1 <= phase[15];
			x2_s1 <= sq[28:14];
			x_s2 <= x_s1;
			neg_s2 <= neg_s1;
			x2_s2 <= x2_s1;
			t_s2 <= 15'(SIN_B - 15'(p2[30:14]));
			x_s3 <= x_s2;
			neg_s3 <= neg_s2;
			t_s3 <= 15'(SIN_A - 15'(p3[30:14]));
			value <= neg_s3 ? -$signed(r4[15:0]) : $signed(r4[15:0]);
		end
	end
endmodule
`default_nettype wire

>>> rtl/uv_sphere_cell_vertex_generator_core.sv
// Top level of the UV sphere cell vertex generator: sequencer, dividers, trig and output.
// A cell issues three vertices (pole bands), six (middle bands) or one (out of range),
// one vertex per cycle while the output is not stalled; the next cell is accepted in the
// cycle its last vertex is issued. From issue to result a vertex passes 17 divider cells,
// four sine stages, two multiplier stages and the output register. Configuration is read
// live, so it must only change while no transaction is in flight.
`default_nettype none
module uv_sphere_cell_vertex_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         band,
	input  logic [7:0]         column,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               last,
	output logic               bad_cell
);
	import usv_pkg::*;

	function automatic logic signed [47:0] rnd(input logic signed [47:0] v, input int s);
		logic signed [47:0] a;
		logic signed [47:0] r;
		a = (v < 0) ? -v : v;
		r = (a + (48'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -r : r;
	endfunction

	function automatic logic [1:0] vert_offset(input cell_kind_t kind, input logic [2:0] k);
		logic [1:0] off;
		off = 2'b00;
		case (kind)
			KIND_TOP: begin
				case (k)
					3'd0: off = 2'b01;
					3'd1: off = 2'b11;
					default: off = 2'b00;
				endcase
			end
			KIND_BOT: begin
				case (k)
					3'd0: off = 2'b01;
					3'd1: off = 2'b10;
					default: off = 2'b00;
				endcase
			end
			KIND_MID: begin
				case (k)
					3'd0, 3'd5: off = 2'b11;
					3'd1: off = 2'b10;
					3'd4: off = 2'b01;
					default: off = 2'b00;
				endcase
			end
			default: off = 2'b00;
		endcase
		return off;
	endfunction

	logic [15:0] radius_q;
	logic [8:0] seg_around_q;
	logic [8:0] seg_pole_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			seg_around_q <= 9'd16;
			seg_pole_q <= 9'd16;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_RADIUS: radius_q <= pwdata[15:0];
				REG_SEG_AROUND: seg_around_q <= pwdata[8:0];
				REG_SEG_POLE: seg_pole_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RADIUS: prdata = {16'b0, radius_q};
			REG_SEG_AROUND: prdata = {23'b0, seg_around_q};
			REG_SEG_POLE: prdata = {23'b0, seg_pole_q};
			default: prdata = '0;
		endcase
	end

	logic en;
	logic out_valid_q;
	logic busy_q;
	cell_kind_t kind_q;
	logic [7:0] b_q;
	logic [7:0] c_q;
	logic [2:0] k_q;
	logic [2:0] k_end;
	logic last_issue;
	logic in_accept;
	logic cfg_bad;
	cell_kind_t new_kind;

	assign en = !(out_valid_q && out_stall);

	always_comb begin
		case (kind_q)
			KIND_BAD: k_end = 3'd0;
			KIND_TOP, KIND_BOT: k_end = 3'd2;
			default: k_end = 3'd5;
		endcase
		last_issue = (k_q == k_end);
		in_stall = busy_q && !(en && last_issue);
		in_accept = in_valid && !in_stall;
		cfg_bad = (seg_around_q < 9'd3) || (seg_pole_q < 9'd2) ||
			(int'(seg_around_q) > MAX_SEGMENTS) || (int'(seg_pole_q) > MAX_SEGMENTS) ||
			({1'b0, band} >= seg_pole_q) || ({1'b0, column} >= seg_around_q);
		if (cfg_bad) begin
			new_kind = KIND_BAD;
		end else if (band == 8'd0) begin
			new_kind = KIND_TOP;
		end else if ({1'b0, band} == seg_pole_q - 9'd1) begin
			new_kind = KIND_BOT;
		end else begin
			new_kind = KIND_MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= KIND_BAD;
			k_q <= '0;
			b_q <= '0;
			c_q <= '0;
		end else if (in_accept) begin
			busy_q <= 1'b1;
			kind_q <= new_kind;
			k_q <= '0;
			b_q <= band;
			c_q <= column;
		end else if (busy_q && en) begin
			if (last_issue) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	logic [1:0] off;
	logic [8:0] col;
	logic [8:0] bnd;
	logic [NUM_W-1:0] tu_num;
	logic [NUM_W-1:0] tv_num;
	logic [NUM_W-1:0] py_num;
	logic [QUO_W-1:0] tu;
	logic [QUO_W-1:0] tv;
	logic [QUO_W-1:0] py;

	always_comb begin
		off = vert_offset(kind_q, k_q);
		col = {1'b0, c_q} + {8'b0, off[1]};
		bnd = {1'b0, b_q} + {8'b0, off[0]};
		tu_num = {col, 16'b0} + NUM_W'(seg_around_q >> 1);
		tv_num = {bnd, 16'b0} + NUM_W'(seg_pole_q >> 1);
		py_num = {1'b0, bnd, 15'b0} + NUM_W'(seg_pole_q >> 1);
	end

	usv_div_chain u_div_u (.clk(clk), .en(en), .num(tu_num), .den(seg_around_q), .quo(tu));
	usv_div_chain u_div_v (.clk(clk), .en(en), .num(tv_num), .den(seg_pole_q), .quo(tv));
	usv_div_chain u_div_y (.clk(clk), .en(en), .num(py_num), .den(seg_pole_q), .quo(py));

	div_tag_t dtag_q [QUO_W];
	vtx_tag_t stag_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++) begin
				dtag_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				stag_q[i] <= '0;
			end
		end else if (en) begin
			dtag_q[0] <= '{valid: busy_q, last: last_issue, bad: kind_q == KIND_BAD};
			for (int i = 1; i < QUO_W; i++) begin
				dtag_q[i] <= dtag_q[i-1];
			end
			stag_q[0] <= '{valid: dtag_q[QUO_W-1].valid, last: dtag_q[QUO_W-1].last,
				bad: dtag_q[QUO_W-1].bad, tu: tu, tv: tv};
			for (int i = 1; i < 4; i++) begin
				stag_q[i] <= stag_q[i-1];
			end
		end
	end

	logic signed [TRIG_W-1:0] sr, cr, sy, cy;

	usv_sine u_sin_r (.clk(clk), .en(en), .phase(tu[15:0]), .value(sr));
	usv_sine u_cos_r (.clk(clk), .en(en), .phase(tu[15:0] + 16'd16384), .value(cr));
	usv_sine u_sin_y (.clk(clk), .en(en), .phase(py[15:0]), .value(sy));
	usv_sine u_cos_y (.clk(clk), .en(en), .phase(py[15:0] + 16'd16384), .value(cy));

	logic signed [31:0] psx_s5, pcz_s5;
	logic signed [33:0] pcy_s5;
	logic signed [15:0] cy_s5;
	vtx_tag_t tag_s5, tag_s6;
	logic signed [47:0] pxr_s6, pzr_s6;
	logic signed [15:0] nx_s6, ny_s6, nz_s6;
	logic signed [16:0] py_s6;
	logic signed [16:0] rad_s;

	assign rad_s = $signed({1'b0, radius_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
			tag_s6 <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			tag_s5 <= stag_q[3];
			tag_s6 <= tag_s5;
			out_valid_q <= tag_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psx_s5 <= 32'(sr) * 32'(sy);
			pcz_s5 <= 32'(cr) * 32'(sy);
			pcy_s5 <= 34'(cy) * 34'(rad_s);
			cy_s5 <= cy;
			pxr_s6 <= 48'(psx_s5) * 48'(rad_s);
			pzr_s6 <= 48'(pcz_s5) * 48'(rad_s);
			nx_s6 <= 16'(rnd(48'(psx_s5), 14));
			nz_s6 <= 16'(-rnd(48'(pcz_s5), 14));
			ny_s6 <= -cy_s5;
			py_s6 <= 17'(-rnd(48'(pcy_s5), 14));
			pos_x <= tag_s6.bad ? '0 : 17'(rnd(pxr_s6, 28));
			pos_y <= tag_s6.bad ? '0 : py_s6;
			pos_z <= tag_s6.bad ? '0 : 17'(-rnd(pzr_s6, 28));
			norm_x <= tag_s6.bad ? '0 : nx_s6;
			norm_y <= tag_s6.bad ? '0 : ny_s6;
			norm_z <= tag_s6.bad ? '0 : nz_s6;
			tex_u <= tag_s6.bad ? '0 : tag_s6.tu;
			tex_v <= tag_s6.bad ? '0 : tag_s6.tv;
			last <= tag_s6.last;
			bad_cell <= tag_s6.bad;
		end
	end

	assign out_valid = out_valid_q;

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_cell |-> last && tex_u == 17'd0 && pos_x == 17'sd0)
		else $error("bad cell result is not a lone zero transaction");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_cell |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
		else $error("texture coordinate out of range");

	a_seq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !en |=> $stable(k_q) && busy_q)
		else $error("sequencer advanced while the pipeline was stalled");
endmodule
`default_nettype wire

>>> bench/uv_sphere_cell_vertex_generator_core_tb.sv
// Testbench for the UV sphere cell vertex generator: random stimulus, fixed-point predictor, scoreboard.
module uv_sphere_cell_vertex_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import usv_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int unsigned SIN_A = 25736;
	localparam int unsigned SIN_B = 10512;
	localparam int unsigned SIN_C = 1160;
	localparam int MID_DC[6] = '{1, 1, 0, 0, 0, 1};
	localparam int MID_DB[6] = '{1, 0, 0, 0, 1, 1};
	localparam int TOP_DC[3] = '{0, 1, 0};
	localparam int TOP_DB[3] = '{1, 1, 0};
	localparam int BOT_DC[3] = '{0, 1, 0};
	localparam int BOT_DB[3] = '{1, 0, 0};

	typedef struct {
		logic signed [16:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [16:0] tu, tv;
		logic lst, bad;
	} vertex_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [7:0] band, column;
	logic out_valid, out_stall;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic [16:0] tex_u, tex_v;
	logic last, bad_cell;

	uv_sphere_cell_vertex_generator_core dut (.*);

	vertex_t expected_vertices[$];
	logic [15:0] cfg_radius;
	logic [8:0] cfg_around, cfg_pole;
	int mismatches, cells_sent, vertices_seen, idle_cycles, stall_left;
	bit no_idle;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int quarter_sine(int unsigned x);
		int unsigned x2, t;
		x2 = (x * x + 8192) >> 14;
		t = (SIN_C * x2 + 8192) >> 14;
		t = SIN_B - t;
		t = (t * x2 + 8192) >> 14;
		t = SIN_A - t;
		t = (x * t + 8192) >> 14;
		if (t > 16384) t = 16384;
		return int'(t);
	endfunction

	function automatic int fixed_sine(int unsigned phase);
		int unsigned p, x;
		int s;
		p = phase & 32'hFFFF;
		x = p & 32'h3FFF;
		if (p[14]) x = 16384 - x;
		s = quarter_sine(x);
		return p[15] ? -s : s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		longint half;
		half = longint'(1) <<< (s - 1);
		if (v >= 0) return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic vertex_t sphere_vertex(int unsigned col, int unsigned bnd, bit lst);
		vertex_t v;
		int unsigned sh, sv, tu, tv, py;
		longint sr, cr, sy, cy, rad;
		sh = cfg_around;
		sv = cfg_pole;
		tu = ((col << 16) + (sh >> 1)) / sh;
		tv = ((bnd << 16) + (sv >> 1)) / sv;
		py = ((bnd << 15) + (sv >> 1)) / sv;
		sr = fixed_sine(tu & 32'hFFFF);
		cr = fixed_sine((tu & 32'hFFFF) + 16384);
		sy = fixed_sine(py);
		cy = fixed_sine(py + 16384);
		rad = cfg_radius;
		v.px = 17'(round_shift(sr * sy * rad, 28));
		v.py = 17'(-round_shift(cy * rad, 14));
		v.pz = 17'(-round_shift(cr * sy * rad, 28));
		v.nx = 16'(round_shift(sr * sy, 14));
		v.ny = 16'(-cy);
		v.nz = 16'(-round_shift(cr * sy, 14));
		v.tu = 17'(tu);
		v.tv = 17'(tv);
		v.lst = lst;
		v.bad = 1'b0;
		return v;
	endfunction

	task automatic predict_cell(int unsigned b, int unsigned c);
		vertex_t v;
		cell_kind_t kind;
		if (cfg_around < 3 || cfg_pole < 2 || cfg_around > MAX_SEGMENTS ||
				cfg_pole > MAX_SEGMENTS || b >= cfg_pole || c >= cfg_around) kind = KIND_BAD;
		else if (b == 0) kind = KIND_TOP;
		else if (b == cfg_pole - 1) kind = KIND_BOT;
		else kind = KIND_MID;
		case (kind)
			KIND_BAD: begin
				v = '{default: 0};
				v.lst = 1'b1;
				v.bad = 1'b1;
				expected_vertices.push_back(v);
			end
			KIND_TOP: begin
				for (int k = 0; k < 3; k++)
					expected_vertices.push_back(sphere_vertex(c + TOP_DC[k], b + TOP_DB[k], k == 2));
			end
			KIND_BOT: begin
				for (int k = 0; k < 3; k++)
					expected_vertices.push_back(sphere_vertex(c + BOT_DC[k], b + BOT_DB[k], k == 2));
			end
			default: begin
				for (int k = 0; k < 6; k++)
					expected_vertices.push_back(sphere_vertex(c + MID_DC[k], b + MID_DB[k], k == 5));
			end
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic report_mismatch(string field, logic [16:0] got, logic [16:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		vertex_t w;
		if (arst_n && out_valid && !out_stall) begin
			vertices_seen++;
			if (expected_vertices.size() == 0) begin
				$display("MISMATCH unexpected vertex at %0t", $realtime);
				mismatches++;
			end else begin
				w = expected_vertices.pop_front();
				if (pos_x !== w.px) report_mismatch("pos_x", pos_x, w.px);
				if (pos_y !== w.py) report_mismatch("pos_y", pos_y, w.py);
				if (pos_z !== w.pz) report_mismatch("pos_z", pos_z, w.pz);
				if (norm_x !== w.nx) report_mismatch("norm_x", norm_x, w.nx);
				if (norm_y !== w.ny) report_mismatch("norm_y", norm_y, w.ny);
				if (norm_z !== w.nz) report_mismatch("norm_z", norm_z, w.nz);
				if (tex_u !== w.tu) report_mismatch("tex_u", tex_u, w.tu);
				if (tex_v !== w.tv) report_mismatch("tex_v", tex_v, w.tv);
				if (last !== w.lst) report_mismatch("last", last, w.lst);
				if (bad_cell !== w.bad) report_mismatch("bad_cell", bad_cell, w.bad);
			end
		end
	end

	always @(posedge clk) begin
		int r;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (!no_idle && r < 15) begin
				out_stall <= 1'b1;
				stall_left <= (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog expired with %0d vertices pending", expected_vertices.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_RADIUS: cfg_radius = value[15:0];
			REG_SEG_AROUND: cfg_around = value[8:0];
			REG_SEG_POLE: cfg_pole = value[8:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [31:0] rad, logic [31:0] sh, logic [31:0] sv);
		write_register(REG_RADIUS, rad);
		write_register(REG_SEG_AROUND, sh);
		write_register(REG_SEG_POLE, sv);
	endtask

	task automatic send_cell(int unsigned b, int unsigned c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		band <= 8'(b);
		column <= 8'(c);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_cell(b, c);
		cells_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_values();
		send_cell(0, 0);
		send_cell(15, 15);
		send_cell(7, 3);
		send_cell(16, 0);
		send_cell(0, 16);
		wait_idle();
	endtask

	task automatic test_extremes();
		configure(32'hFFFF_FFFF, 256, 256);
		send_cell(0, 0);
		send_cell(255, 255);
		send_cell(128, 200);
		send_cell(254, 1);
		wait_idle();
		configure(0, 3, 2);
		send_cell(0, 0);
		send_cell(1, 2);
		send_cell(2, 0);
		send_cell(0, 3);
		wait_idle();
		write_register(REG_UNUSED, 32'h0000_0001);
		configure(1, 2, 5);
		send_cell(1, 1);
		wait_idle();
		configure(300, 257, 5);
		send_cell(1, 1);
		wait_idle();
		configure(300, 8, 1);
		send_cell(0, 0);
		wait_idle();
		configure(300, 8, 257);
		send_cell(0, 0);
		wait_idle();
	endtask

	task automatic test_random_cells();
		int unsigned sh, sv;
		for (int phase = 0; phase < 6; phase++) begin
			no_idle = (phase == 2);
			if (phase == 5) begin
				sh = 256;
				sv = 256;
			end else begin
				sh = $urandom_range(3, 40);
				sv = $urandom_range(2, 40);
			end
			configure($urandom_range(0, 65535), sh, sv);
			for (int i = 0; i < 25; i++) begin
				if ($urandom_range(0, 9) == 0) send_cell($urandom_range(0, 255), $urandom_range(0, 255));
				else send_cell($urandom_range(0, sv - 1), $urandom_range(0, sh - 1));
			end
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		band = '0;
		column = '0;
		out_stall = 1'b0;
		stall_left = 0;
		mismatches = 0;
		cells_sent = 0;
		vertices_seen = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		cfg_radius = 16'd256;
		cfg_around = 9'd16;
		cfg_pole = 9'd16;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_extremes();
		test_random_cells();
		$display("Sent %0d cells and checked %0d vertices over pole, middle and bad cells.",
			cells_sent, vertices_seen);
		$display("Configurations ranged from minimal to 256 segments, radius zero to maximum.");
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

>>> uv_sphere_cell_vertex_generator_core.f
rtl/usv_pkg.sv
rtl/usv_div_cell.sv
rtl/usv_div_chain.sv
rtl/usv_sine.sv
rtl/uv_sphere_cell_vertex_generator_core.sv
bench/uv_sphere_cell_vertex_generator_core_tb.sv
